@@ rtl/battery_coulomb_gauge_macros.svh @@
// Assertion macros for the battery gauge checker.
// No dependencies; taken in by the checker through `include.
`ifndef BATTERY_COULOMB_GAUGE_MACROS_SVH
`define BATTERY_COULOMB_GAUGE_MACROS_SVH

// same-cycle implication
`define BCG_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("battery gauge check failed");

// next-cycle implication
`define BCG_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("battery gauge check failed");

`endif

@@ rtl/bcg_pkg.sv @@
// Shared types and constants of the battery coulomb gauge.
// No dependencies.
package bcg_pkg;

  typedef enum logic [1:0] {
    CMD_SAMPLE  = 2'd0,
    CMD_ACCEPT  = 2'd1,
    CMD_PREEMPT = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_DISCHG = 2'd1,
    ST_CHG    = 2'd2,
    ST_FAULT  = 2'd3
  } status_e;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_CHG_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIS_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY  = 2'd2;

  localparam int QUEUE_DEPTH = 2;
  localparam int NUM_W = 64;
  localparam int DEN_W = 40;

  localparam logic [9:0]  WINDOW_BASE = 10'd100;
  localparam logic [9:0]  CODE_CLEAR  = 10'd5;
  localparam logic [13:0] SOC_SCALE   = 14'd10000;
  localparam logic [6:0]  EST_SCALE   = 7'd100;
  localparam logic signed [21:0] SOC_FULL = 22'sd10000;
  localparam logic [63:0] SOC_LIMIT   = 64'd1000000;

  typedef struct packed {
    cmd_e               cmd;
    logic signed [15:0] cur;
    logic [9:0]         code;
  } entry_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quo;
  } div_rsp_t;

  typedef enum logic [3:0] {
    BK_IDLE, BK_PREP, BK_CGO, BK_CWAIT, BK_SGO, BK_SWAIT,
    BK_WIN, BK_EMUL1, BK_EMUL2, BK_EGO, BK_EWAIT, BK_OUT
  } back_state_e;

endpackage

@@ rtl/bcg_ifs.sv @@
// Channel interfaces of the battery gauge: samples in, results out, config writes.
// No dependencies.
interface bcg_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic signed [15:0] current_milli;
  logic [9:0]         request_code;
  modport source (output valid, command, current_milli, request_code, input ready);
  modport sink   (input valid, command, current_milli, request_code, output ready);
endinterface

interface bcg_out_if;
  logic               valid;
  logic               ready;
  logic               over_charge;
  logic               over_discharge;
  logic signed [31:0] charge_milli;
  logic signed [20:0] soc_hundredths;
  logic [1:0]         battery_status;
  logic signed [31:0] time_to_full;
  logic signed [31:0] time_to_empty;
  logic               request_done;
  modport source (output valid, over_charge, over_discharge, charge_milli, soc_hundredths,
                  battery_status, time_to_full, time_to_empty, request_done, input ready);
  modport sink   (input valid, over_charge, over_discharge, charge_milli, soc_hundredths,
                  battery_status, time_to_full, time_to_empty, request_done, output ready);
endinterface

interface bcg_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/bcg_front.sv @@
// Front end: accepts input items, drops CMD_NONE items, pushes the rest.
// Depends on bcg_pkg and bcg_ifs.
module bcg_front (
  bcg_in_if.sink         in_i,
  input  logic           q_full_i,
  output logic           push_o,
  output bcg_pkg::entry_t entry_o
);
  import bcg_pkg::*;

  logic is_none;

  assign is_none    = (cmd_e'(in_i.command) == CMD_NONE);
  assign in_i.ready = is_none || !q_full_i;
  assign push_o     = in_i.valid && !is_none && !q_full_i;

  always_comb begin
    entry_o.cmd  = cmd_e'(in_i.command);
    entry_o.cur  = in_i.current_milli;
    entry_o.code = in_i.request_code;
  end
endmodule

@@ rtl/bcg_queue.sv @@
// Short queue of commands between front and back.
// Depends on bcg_pkg.
module bcg_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  bcg_pkg::entry_t entry_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output bcg_pkg::entry_t entry_o
);
  import bcg_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  entry_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_q, rd_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign entry_o = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      if (do_pop)  rd_q <= (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      cnt_q <= cnt_q + CNT_W'(do_push) - CNT_W'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= entry_i;
  end
endmodule

@@ rtl/bcg_div.sv @@
// Restoring serial divider, one quotient bit per cycle, unsigned.
// Depends on bcg_pkg.
module bcg_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bcg_pkg::div_req_t req_i,
  output bcg_pkg::div_rsp_t rsp_o
);
  import bcg_pkg::*;

  localparam int CNT_W = $clog2(NUM_W);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [NUM_W-1:0] n_q;
  logic [DEN_W-1:0] d_q, r_q;
  logic [DEN_W:0]   trial;
  logic             fits;

  assign trial = {r_q, n_q[NUM_W-1]};
  assign fits  = (trial >= {1'b0, d_q});
  assign rsp_o.done = done_q;
  assign rsp_o.quo  = n_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      n_q <= req_i.num;
      d_q <= req_i.den;
      r_q <= '0;
    end else if (busy_q) begin
      r_q <= fits ? DEN_W'(trial - {1'b0, d_q}) : trial[DEN_W-1:0];
      n_q <= {n_q[NUM_W-2:0], fits};
    end
  end
endmodule

@@ rtl/bcg_back.sv @@
// Back end: config registers, charge and window state, estimate sequencer, result register.
// Depends on bcg_pkg, bcg_ifs; drives the shared divider.
module bcg_back #(
  parameter int TICKS = 36000
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  bcg_cfg_if.sink           cfg_i,
  input  logic              q_valid_i,
  input  bcg_pkg::entry_t   q_entry_i,
  output logic              q_pop_o,
  output bcg_pkg::div_req_t div_req_o,
  input  bcg_pkg::div_rsp_t div_rsp_i,
  bcg_out_if.source         out_o
);
  import bcg_pkg::*;

  // charge = mag / TICKS as (mag * RECIP) >> 68; exact for mag <= 2^47, TICKS < 2^20
  localparam logic [68:0] RECIP =
    69'(((70'd1 << 68) + 70'(TICKS) - 70'd1) / 70'(TICKS));
  localparam logic [2:0] PP_LAST = 3'd5;

  back_state_e state_q, state_d;

  logic signed [15:0] cl_q, dl_q;
  logic [15:0]        cap_q, cap_eff;
  logic signed [47:0] acc_q;
  logic signed [31:0] wsum_q, s_q;
  logic [9:0]         wcnt_q, code_q, n_win;
  status_e            status_q;
  logic               active_q;
  logic signed [31:0] full_q, empty_q, charge_q;
  logic signed [20:0] soc_q;
  logic signed [15:0] cur_q;
  logic               ovc_q, ovd_q, done_q, accneg_q, xneg_q;
  logic [47:0]        mag_q;
  logic [37:0]        plo_q, phi_q;
  logic [63:0]        sprod_q;
  logic [DEN_W-1:0]   den_soc_q, dene_q;
  logic [20:0]        xmag_q;
  logic [36:0]        m1_q;
  logic [46:0]        m2_q;
  logic               out_free;
  logic [2:0]         pstep_q;
  logic [115:0]       pacc_q;

  logic signed [48:0] acc_sum;
  logic signed [32:0] wsum_sum;
  logic [9:0]         wcnt_inc;
  logic signed [21:0] xval;
  status_e            st_new;
  logic [23:0]        pp_a;
  logic [22:0]        pp_b;
  logic [6:0]         pp_shift;
  logic [46:0]        pp;
  logic [115:0]       pp_sh;

  function automatic logic signed [31:0] sat32(input logic neg, input logic [63:0] q);
    if (!neg) return (q > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(q);
    else      return (q > 64'h8000_0000) ? 32'sh8000_0000 : -32'(q);
  endfunction

  function automatic logic signed [20:0] sat_soc(input logic neg, input logic [63:0] q);
    logic signed [20:0] lim;
    lim = 21'(SOC_LIMIT);
    if (q > SOC_LIMIT) return neg ? -lim : lim;
    else               return neg ? -21'(q) : 21'(q);
  endfunction

  assign cfg_i.ready = 1'b1;
  assign cap_eff  = (cap_q == '0) ? 16'd1 : cap_q;
  assign n_win    = code_q - WINDOW_BASE;
  assign out_free = !out_o.valid || out_o.ready;
  assign acc_sum  = 49'(acc_q) + 49'(q_entry_i.cur);
  assign wsum_sum = 33'(wsum_q) + 33'(cur_q);
  assign wcnt_inc = wcnt_q + 1'b1;

  // partial products of the charge reciprocal multiply, one per step
  always_comb begin
    pp_a     = mag_q[23:0];
    pp_b     = RECIP[22:0];
    pp_shift = 7'd0;
    case (pstep_q)
      3'd0: begin pp_a = mag_q[23:0];  pp_b = RECIP[22:0];  pp_shift = 7'd0;  end
      3'd1: begin pp_a = mag_q[23:0];  pp_b = RECIP[45:23]; pp_shift = 7'd23; end
      3'd2: begin pp_a = mag_q[23:0];  pp_b = RECIP[68:46]; pp_shift = 7'd46; end
      3'd3: begin pp_a = mag_q[47:24]; pp_b = RECIP[22:0];  pp_shift = 7'd24; end
      3'd4: begin pp_a = mag_q[47:24]; pp_b = RECIP[45:23]; pp_shift = 7'd47; end
      3'd5: begin pp_a = mag_q[47:24]; pp_b = RECIP[68:46]; pp_shift = 7'd70; end
      default: ;
    endcase
  end

  assign pp    = 47'(pp_a) * 47'(pp_b);
  assign pp_sh = 116'(pp) << pp_shift;

  // next state and divider / queue control
  always_comb begin
    state_d   = state_q;
    q_pop_o   = 1'b0;
    div_req_o = '0;
    case (state_q)
      BK_IDLE: begin
        q_pop_o = q_valid_i;
        if (q_valid_i && q_entry_i.cmd == CMD_SAMPLE && active_q) state_d = BK_PREP;
      end
      BK_PREP: state_d = BK_CGO;
      BK_CGO: state_d = BK_CWAIT;
      BK_CWAIT: if (pstep_q == PP_LAST) state_d = BK_SGO;
      BK_SGO: begin
        div_req_o.start = 1'b1;
        div_req_o.num   = sprod_q;
        div_req_o.den   = den_soc_q;
        state_d = BK_SWAIT;
      end
      BK_SWAIT: if (div_rsp_i.done) state_d = BK_WIN;
      BK_WIN: begin
        if (code_q >= WINDOW_BASE && n_win != '0 && wcnt_inc == n_win) state_d = BK_EMUL1;
        else state_d = BK_OUT;
      end
      BK_EMUL1: state_d = BK_EMUL2;
      BK_EMUL2: state_d = (s_q == '0) ? BK_OUT : BK_EGO;
      BK_EGO: begin
        div_req_o.start = 1'b1;
        div_req_o.num   = NUM_W'(m2_q);
        div_req_o.den   = dene_q;
        state_d = BK_EWAIT;
      end
      BK_EWAIT: if (div_rsp_i.done) state_d = BK_OUT;
      BK_OUT: if (out_free) state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  // status from the sample sign; fault latches until the clear request code
  always_comb begin
    st_new = status_q;
    if (status_q != ST_FAULT) begin
      if (cur_q == '0)     st_new = ST_IDLE;
      else if (cur_q < 0)  st_new = ST_DISCHG;
      else                 st_new = ST_CHG;
      if (ovc_q || ovd_q)  st_new = ST_FAULT;
    end
    if (code_q == CODE_CLEAR) st_new = ST_IDLE;
  end

  // estimate operand: room to full when the window sum is zero or positive, charge left when negative
  assign xval = (wsum_sum[32] != wsum_sum[31])
              ? (wsum_sum[32] ? 22'(soc_q) : SOC_FULL - 22'(soc_q))
              : (wsum_sum[31] ? 22'(soc_q) : SOC_FULL - 22'(soc_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= BK_IDLE;
      cl_q     <= 16'sd5000;
      dl_q     <= -16'sd10000;
      cap_q    <= 16'd5000;
      acc_q    <= '0;
      wsum_q   <= '0;
      wcnt_q   <= '0;
      status_q <= ST_IDLE;
      active_q <= 1'b0;
      code_q   <= '0;
      full_q   <= '0;
      empty_q  <= '0;
      done_q   <= 1'b0;
      out_o.valid <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid) begin
        case (cfg_i.index)
          CFG_CHG_LIMIT: cl_q  <= cfg_i.data;
          CFG_DIS_LIMIT: dl_q  <= cfg_i.data;
          CFG_CAPACITY:  cap_q <= cfg_i.data;
          default: ;
        endcase
      end
      if (state_q == BK_OUT && out_free) out_o.valid <= 1'b1;
      else if (out_o.ready)              out_o.valid <= 1'b0;
      case (state_q)
        BK_IDLE: begin
          if (q_valid_i) begin
            case (q_entry_i.cmd)
              CMD_ACCEPT: begin
                code_q   <= q_entry_i.code;
                active_q <= 1'b1;
              end
              CMD_PREEMPT: active_q <= 1'b0;
              CMD_SAMPLE: begin
                if (active_q) begin
                  if (acc_sum[48] != acc_sum[47])
                    acc_q <= acc_sum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
                  else
                    acc_q <= acc_sum[47:0];
                  done_q <= 1'b0;
                end
              end
              default: ;
            endcase
          end
        end
        BK_WIN: begin
          status_q <= st_new;
          if (code_q >= WINDOW_BASE) begin
            wcnt_q <= wcnt_inc;
            if (wsum_sum[32] != wsum_sum[31])
              wsum_q <= wsum_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            else
              wsum_q <= wsum_sum[31:0];
            if (n_win != '0 && wcnt_inc == n_win) begin
              wcnt_q   <= '0;
              wsum_q   <= '0;
              active_q <= 1'b0;
              done_q   <= 1'b1;
            end
          end
        end
        BK_EMUL2: begin
          if (s_q == '0) full_q <= xneg_q ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        BK_EWAIT: begin
          if (div_rsp_i.done) begin
            if (s_q < 0) empty_q <= sat32(xneg_q ^ 1'b1, div_rsp_i.quo);
            else         full_q  <= sat32(xneg_q, div_rsp_i.quo);
          end
        end
        default: ;
      endcase
    end
  end

  // datapath work registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      BK_IDLE: begin
        cur_q <= q_entry_i.cur;
        ovc_q <= q_entry_i.cur > cl_q;
        ovd_q <= q_entry_i.cur < dl_q;
        den_soc_q <= DEN_W'(TICKS) * DEN_W'(cap_eff);
      end
      BK_PREP: begin
        accneg_q <= acc_q[47];
        mag_q    <= acc_q[47] ? 48'(-acc_q) : 48'(acc_q);
      end
      BK_CGO: begin
        plo_q   <= 38'(mag_q[23:0]) * 38'(SOC_SCALE);
        phi_q   <= 38'(mag_q[47:24]) * 38'(SOC_SCALE);
        pacc_q  <= '0;
        pstep_q <= '0;
      end
      BK_CWAIT: begin
        sprod_q <= {phi_q[37:0], 24'd0} + 64'(plo_q);
        pacc_q  <= pacc_q + pp_sh;
        pstep_q <= pstep_q + 1'b1;
      end
      BK_SGO: charge_q <= sat32(accneg_q, 64'(pacc_q[115:68]));
      BK_SWAIT: if (div_rsp_i.done) soc_q <= sat_soc(accneg_q, div_rsp_i.quo);
      BK_WIN: begin
        s_q <= (wsum_sum[32] != wsum_sum[31])
             ? (wsum_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : wsum_sum[31:0];
        xneg_q <= xval[21];
        xmag_q <= xval[21] ? 21'(-xval) : 21'(xval);
      end
      BK_EMUL1: begin
        m1_q   <= 37'(xmag_q) * 37'(cap_eff);
        dene_q <= DEN_W'(s_q[31] ? 33'(-33'(s_q)) : 33'(s_q)) * DEN_W'(EST_SCALE);
      end
      BK_EMUL2: m2_q <= 47'(m1_q) * 47'(n_win);
      BK_OUT: begin
        if (out_free) begin
          out_o.over_charge    <= ovc_q;
          out_o.over_discharge <= ovd_q;
          out_o.charge_milli   <= charge_q;
          out_o.soc_hundredths <= soc_q;
          out_o.battery_status <= status_q;
          out_o.time_to_full   <= full_q;
          out_o.time_to_empty  <= empty_q;
          out_o.request_done   <= done_q;
        end
      end
      default: ;
    endcase
  end
endmodule

@@ rtl/battery_coulomb_gauge.sv @@
// Top level of the battery coulomb gauge: front, command queue, back end, divider.
// Depends on bcg_pkg, bcg_ifs, bcg_front, bcg_queue, bcg_div, bcg_back.
//
//  channel  | dir | payload                                   | handshake
//  ---------+-----+-------------------------------------------+----------------
//  in_i     | in  | command, current_milli, request_code      | valid/ready
//  out_o    | out | flags, charge, soc, status, estimates,done| valid/ready
//  cfg_i    | in  | index (0..2 used), data 16 bit            | valid/ready, ready=1
//
// Accept and preempt requests are handled in the idle state. A sample with an
// active request takes six steps of the reciprocal multiply for the charge,
// then one pass of the 64-step serial divider for state of charge. A sample
// that closes a window adds the multiply states EMUL1, EMUL2 and a second divider
// pass; a zero window sum skips that divide. Reset is asynchronous, active low;
// it restores the config defaults and clears the charge accumulator, window,
// request and status state. The two-entry queue lets the input side keep accepting
// while the back end computes or holds a result that the output has not taken.
module battery_coulomb_gauge #(
  parameter int TICKS_PER_CHARGE_UNIT = 36000
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bcg_in_if.sink    in_i,
  bcg_cfg_if.sink   cfg_i,
  bcg_out_if.source out_o
);
  import bcg_pkg::*;

  // front to queue
  logic     push, q_full;
  entry_t   push_entry;
  // queue to back
  logic     q_valid, q_pop;
  entry_t   q_entry;
  // back to divider
  div_req_t div_req;
  div_rsp_t div_rsp;

  bcg_front u_front (
    .in_i     (in_i),
    .q_full_i (q_full),
    .push_o   (push),
    .entry_o  (push_entry)
  );

  bcg_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .entry_o (q_entry)
  );

  // one divider shared by state of charge and the estimates
  bcg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  bcg_back #(
    .TICKS (TICKS_PER_CHARGE_UNIT)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_i),
    .q_valid_i (q_valid),
    .q_entry_i (q_entry),
    .q_pop_o   (q_pop),
    .div_req_o (div_req),
    .div_rsp_i (div_rsp),
    .out_o     (out_o)
  );
endmodule

@@ rtl/bcg_checker.sv @@
// Port-level checks on the gauge result channel, bound to the top level.
// Depends on battery_coulomb_gauge_macros.svh.
`include "battery_coulomb_gauge_macros.svh"

module bcg_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] charge,
  input logic signed [20:0] soc
);
  `BCG_ASSERT_NXT(a_valid_holds, clk_i, rst_ni, out_valid && !out_ready, out_valid)
  `BCG_ASSERT_NXT(a_charge_holds, clk_i, rst_ni, out_valid && !out_ready, $stable(charge))
  `BCG_ASSERT_IMP(a_soc_range, clk_i, rst_ni, out_valid, soc <= 21'sd1000000 && soc >= -21'sd1000000)
  `BCG_ASSERT_IMP(a_sign_match, clk_i, rst_ni, out_valid, !(charge < 0 && soc > 0) && !(charge > 0 && soc < 0))
endmodule

bind battery_coulomb_gauge bcg_checker u_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .charge    (out_o.charge_milli),
  .soc       (out_o.soc_hundredths)
);
